// File: hw/rtl/cse_pkg.sv
package cse_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int MAX_RESULTS     = 16;

	localparam logic [12:0] FULL_MV     = 13'd5000;
	localparam logic [12:0] HIGH_THR_RST = 13'd3000;
	localparam logic [12:0] LOW_THR_RST  = 13'd2000;
	localparam logic [3:0]  MAX_DLC     = 4'd8;
	localparam int          PROD_W      = 45;

	// opcodes
	localparam logic OP_FRAME    = 1'b0;
	localparam logic OP_TABLE_WR = 1'b1;

	// configuration register indexes
	localparam logic CFG_HIGH_THR = 1'b0;
	localparam logic CFG_LOW_THR  = 1'b1;

	// value types
	localparam logic [2:0] VT_BOOL = 3'd0;
	localparam logic [2:0] VT_U16  = 3'd1;
	localparam logic [2:0] VT_U32  = 3'd2;
	localparam logic [2:0] VT_I16  = 3'd3;
	localparam logic [2:0] VT_I32  = 3'd4;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  bus;
		logic [28:0] frame_id;
		logic [3:0]  dlc;
		logic [63:0] payload;
		logic [3:0]  entry_index;
		logic        entry_used;
		logic [2:0]  entry_offset;
		logic [2:0]  entry_type;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  match_index;
		logic [1:0]  status;
		logic [12:0] level_mv;
		logic        trigger_out;
		logic        last;
	} result_t;

	// table entry load, broadcast to all cells
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic        used;
		logic [1:0]  bus;
		logic [28:0] id;
		logic [2:0]  offset;
		logic [2:0]  etype;
	} tbl_wr_t;

	// what a cell reports while it holds the scan token; all zero otherwise
	typedef struct packed {
		logic       hit;
		logic [2:0] offset;
		logic [2:0] etype;
		logic       trig;
	} cell_rec_t;

	// x / (2^k - 1) for x < 5000 * 2^k: x = q0*(2^k-1) + (q0 + r), one correction
	function automatic logic [12:0] scale_div(input logic [PROD_W-1:0] prod,
			input logic [2:0] vt);
		logic [12:0] q0;
		logic [31:0] r;
		logic [32:0] dv;
		logic [32:0] sum;
		q0 = '0;
		r  = '0;
		dv = '1;
		case (vt)
			VT_U16: begin
				q0 = prod[28:16];
				r  = {16'd0, prod[15:0]};
				dv = 33'h0_0000_FFFF;
			end
			VT_U32: begin
				q0 = prod[44:32];
				r  = prod[31:0];
				dv = 33'h0_FFFF_FFFF;
			end
			VT_I16: begin
				q0 = prod[27:15];
				r  = {17'd0, prod[14:0]};
				dv = 33'h0_0000_7FFF;
			end
			VT_I32: begin
				q0 = prod[43:31];
				r  = {1'b0, prod[30:0]};
				dv = 33'h0_7FFF_FFFF;
			end
			default: begin
				q0 = '0;
				r  = '0;
				dv = '1;
			end
		endcase
		sum = {20'd0, q0} + {1'b0, r};
		return q0 + {12'd0, (sum >= dv)};
	endfunction

endpackage

// File: hw/rtl/cse_cell.sv
module cse_cell import cse_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
	parameter int CELL_IDX    = 0
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       tok_in,
	input  tbl_wr_t                                    wr,
	input  logic [1:0]                                 frm_bus,
	input  logic [28:0]                                frm_id,
	input  logic                                       trig_we,
	input  logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] trig_idx,
	input  logic                                       trig_val,
	output logic                                       tok,
	output cell_rec_t                                  rec
);

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	logic        tok_q;
	logic        used_q;
	logic        trig_q;
	logic [1:0]  bus_q;
	logic [28:0] id_q;
	logic [2:0]  off_q;
	logic [2:0]  type_q;

	logic wr_sel;

	assign wr_sel = wr.en && (int'(wr.index) == CELL_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			used_q <= 1'b0;
			trig_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (wr_sel) begin
				used_q <= wr.used;
			end
			if (trig_we && (trig_idx == IDX_W'(CELL_IDX))) begin
				trig_q <= trig_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			bus_q  <= wr.bus;
			id_q   <= wr.id;
			off_q  <= wr.offset;
			type_q <= wr.etype;
		end
	end

	assign tok = tok_q;

	always_comb begin
		rec = '0;
		if (tok_q) begin
			rec.hit    = used_q && (bus_q == frm_bus) && (id_q == frm_id);
			rec.offset = off_q;
			rec.etype  = type_q;
			rec.trig   = trig_q;
		end
	end

endmodule

// File: hw/rtl/cse_eval.sv
module cse_eval import cse_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_v,
	input  logic                                       in_end,
	input  logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] in_idx,
	input  cell_rec_t                                  in_rec,
	input  logic [3:0]                                 dlc,
	input  logic [63:0]                                payload,
	input  logic [12:0]                                high_thr,
	input  logic [12:0]                                low_thr,
	output logic                                       trig_we,
	output logic [((NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1)-1:0] trig_idx,
	output logic                                       trig_val,
	output logic                                       out_v,
	output logic                                       out_end,
	output result_t                                    out_res
);

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// s1: length check and field extraction
	logic [2:0]  fsize;
	logic [3:0]  fend;
	logic [1:0]  status_c;
	logic [63:0] shifted;
	logic [31:0] raw;
	logic [31:0] mag_c;

	logic             v_s1, end_s1, trig_s1, bnz_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [1:0]       status_s1;
	logic [2:0]       vt_s1;
	logic [31:0]      mag_s1;

	// s2: product
	logic              v_s2, end_s2, trig_s2, bnz_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [1:0]        status_s2;
	logic [2:0]        vt_s2;
	logic [PROD_W-1:0] prod_s2;

	// s3: level
	logic             v_s3, end_s3, trig_s3;
	logic [IDX_W-1:0] idx_s3;
	logic [1:0]       status_s3;
	logic [12:0]      level_s3;

	logic [12:0] level_c;
	logic        trig_new;

	always_comb begin
		case (in_rec.etype)
			VT_BOOL: fsize = 3'd1;
			VT_U16:  fsize = 3'd2;
			VT_U32:  fsize = 3'd4;
			VT_I16:  fsize = 3'd2;
			VT_I32:  fsize = 3'd4;
			default: fsize = 3'd0;
		endcase
		fend = {1'b0, in_rec.offset} + {1'b0, fsize};
		if (fsize == 3'd0) begin
			status_c = ST_UNSUP;
		end else if (fend > dlc) begin
			status_c = ST_SHORT;
		end else begin
			status_c = ST_OK;
		end
		shifted = payload >> {in_rec.offset, 3'b000};
		raw     = shifted[31:0];
		// negative signed values go to zero
		case (in_rec.etype)
			VT_U16:  mag_c = {16'd0, raw[15:0]};
			VT_U32:  mag_c = raw;
			VT_I16:  mag_c = raw[15] ? 32'd0 : {17'd0, raw[14:0]};
			VT_I32:  mag_c = raw[31] ? 32'd0 : {1'b0, raw[30:0]};
			default: mag_c = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			end_s1 <= 1'b0;
			v_s2   <= 1'b0;
			end_s2 <= 1'b0;
			v_s3   <= 1'b0;
			end_s3 <= 1'b0;
			out_v  <= 1'b0;
			out_end <= 1'b0;
		end else begin
			v_s1    <= in_v;
			end_s1  <= in_end;
			v_s2    <= v_s1;
			end_s2  <= end_s1;
			v_s3    <= v_s2;
			end_s3  <= end_s2;
			out_v   <= v_s3;
			out_end <= end_s3;
		end
	end

	always_comb begin
		if (status_s2 != ST_OK) begin
			level_c = '0;
		end else if (vt_s2 == VT_BOOL) begin
			level_c = bnz_s2 ? FULL_MV : 13'd0;
		end else begin
			level_c = scale_div(prod_s2, vt_s2);
		end
	end

	// hysteresis; set test wins when thresholds cross
	always_comb begin
		if (level_s3 > high_thr) begin
			trig_new = 1'b1;
		end else if (level_s3 < low_thr) begin
			trig_new = 1'b0;
		end else begin
			trig_new = trig_s3;
		end
		if (status_s3 != ST_OK) begin
			trig_new = trig_s3;
		end
	end

	assign trig_we  = v_s3 && (status_s3 == ST_OK);
	assign trig_idx = idx_s3;
	assign trig_val = trig_new;

	always_ff @(posedge clk) begin
		idx_s1    <= in_idx;
		status_s1 <= status_c;
		vt_s1     <= in_rec.etype;
		mag_s1    <= mag_c;
		bnz_s1    <= (raw[7:0] != 8'd0);
		trig_s1   <= in_rec.trig;

		idx_s2    <= idx_s1;
		status_s2 <= status_s1;
		vt_s2     <= vt_s1;
		bnz_s2    <= bnz_s1;
		trig_s2   <= trig_s1;
		prod_s2   <= PROD_W'(mag_s1) * PROD_W'(FULL_MV);

		idx_s3    <= idx_s2;
		status_s3 <= status_s2;
		trig_s3   <= trig_s2;
		level_s3  <= level_c;

		out_res.match_index <= 4'(idx_s3);
		out_res.status      <= status_s3;
		out_res.level_mv    <= level_s3;
		out_res.trigger_out <= trig_new;
		out_res.last        <= 1'b0;
	end

endmodule

// File: hw/rtl/can_signal_extract_schmitt.sv
// channel   dir  handshake                    beat
// --------  ---  ---------------------------  ------------------------------
// in_item   in   start & !busy                one frame or one table write
// result    out  result_valid, one cycle      one matching entry, in order
// cfg       in   cfg_we                       one threshold register
//
// A table write leaves busy low.
// A frame holds busy high from accept until its scan is done: a token walks
// the row of entry cells one per cycle, then a four-stage scale/compare pipe.
// Results of a frame come out in entry order, the last one marked by last.
// Reset clears all used flags and trigger bits and loads the default thresholds.
// result_valid is high for exactly one cycle per beat; there is no back-pressure.
module can_signal_extract_schmitt import cse_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    in_item,
	output logic        result_valid,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_wdata
);

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	logic        busy_q;
	logic        done_q;
	logic [12:0] high_thr_q;
	logic [12:0] low_thr_q;
	logic [CNT_W-1:0] hit_cnt_q;

	logic [1:0]  frm_bus_q;
	logic [28:0] frm_id_q;
	logic [3:0]  frm_dlc_q;
	logic [63:0] frm_payload_q;

	logic    accept;
	logic    accept_frame;
	tbl_wr_t tbl_wr;

	logic [NUM_ENTRIES-1:0] tok_w;
	cell_rec_t              rec_w [NUM_ENTRIES];

	cell_rec_t        sel_rec;
	logic [IDX_W-1:0] sel_idx;
	logic             sel_v;

	logic             trig_we;
	logic [IDX_W-1:0] trig_idx;
	logic             trig_val;

	logic    ev_v;
	logic    ev_end;
	result_t ev_res;

	logic    pend_v_q;
	result_t pend_q;
	result_t pend_last;
	logic    result_valid_q;
	result_t result_q;

	assign accept       = start && !busy_q;
	assign accept_frame = accept && (in_item.opcode == OP_FRAME);
	assign busy         = busy_q;

	always_comb begin
		tbl_wr        = '0;
		tbl_wr.en     = accept && (in_item.opcode == OP_TABLE_WR);
		tbl_wr.index  = in_item.entry_index;
		tbl_wr.used   = in_item.entry_used;
		tbl_wr.bus    = in_item.bus;
		tbl_wr.id     = in_item.frame_id;
		tbl_wr.offset = in_item.entry_offset;
		tbl_wr.etype  = in_item.entry_type;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RST;
			low_thr_q  <= LOW_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HIGH_THR: high_thr_q <= cfg_wdata;
				CFG_LOW_THR:  low_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_frame) begin
			frm_bus_q     <= in_item.bus;
			frm_id_q      <= in_item.frame_id;
			frm_dlc_q     <= (in_item.dlc > MAX_DLC) ? MAX_DLC : in_item.dlc;
			frm_payload_q <= in_item.payload;
		end
	end

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
		cse_cell #(
			.NUM_ENTRIES (NUM_ENTRIES),
			.CELL_IDX    (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   ((g == 0) ? accept_frame : tok_w[(g == 0) ? 0 : g - 1]),
			.wr       (tbl_wr),
			.frm_bus  (frm_bus_q),
			.frm_id   (frm_id_q),
			.trig_we  (trig_we),
			.trig_idx (trig_idx),
			.trig_val (trig_val),
			.tok      (tok_w[g]),
			.rec      (rec_w[g])
		);
	end

	// only the cell holding the token drives a nonzero record
	always_comb begin
		sel_rec = '0;
		sel_idx = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			sel_rec = sel_rec | rec_w[i];
			sel_idx = sel_idx | (tok_w[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	assign sel_v = sel_rec.hit && (hit_cnt_q < CNT_W'(MAX_RESULTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			hit_cnt_q <= '0;
		end else begin
			done_q <= tok_w[NUM_ENTRIES-1];
			if (accept_frame) begin
				hit_cnt_q <= '0;
			end else if (sel_v) begin
				hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
		end
	end

	cse_eval #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (sel_v),
		.in_end   (done_q),
		.in_idx   (sel_idx),
		.in_rec   (sel_rec),
		.dlc      (frm_dlc_q),
		.payload  (frm_payload_q),
		.high_thr (high_thr_q),
		.low_thr  (low_thr_q),
		.trig_we  (trig_we),
		.trig_idx (trig_idx),
		.trig_val (trig_val),
		.out_v    (ev_v),
		.out_end  (ev_end),
		.out_res  (ev_res)
	);

	// hold one result back so the final one of a frame can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pend_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (accept_frame) begin
				busy_q <= 1'b1;
			end else if (ev_end) begin
				busy_q <= 1'b0;
			end
			if (ev_v) begin
				result_valid_q <= pend_v_q;
				pend_v_q       <= 1'b1;
			end else if (ev_end) begin
				result_valid_q <= pend_v_q;
				pend_v_q       <= 1'b0;
			end
		end
	end

	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ev_v) begin
			result_q <= pend_q;
			pend_q   <= ev_res;
		end else if (ev_end) begin
			result_q <= pend_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: tb/sv/cse_result_checker.sv
module cse_result_checker import cse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  in_item_t    in_item,
	input  logic        result_valid,
	input  result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_wdata,
	output int          pending,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        used;
		logic [1:0]  bus;
		logic [28:0] id;
		logic [2:0]  offset;
		logic [2:0]  vtype;
	} filter_entry_t;

	filter_entry_t filters [NUM_ENTRIES_DEF];
	logic          trig [NUM_ENTRIES_DEF];
	logic [12:0]   high_mv;
	logic [12:0]   low_mv;
	result_t       match_q [$];
	result_t       want;
	int            pend_cnt = 0;
	int            err_cnt = 0;

	assign pending    = pend_cnt;
	assign mismatches = err_cnt;

	task automatic report_mismatch(input string msg);
		// keep the log short if everything goes wrong
		if (err_cnt < 40)
			$display("%0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic int field_bytes(input logic [2:0] vt);
		case (vt)
			VT_BOOL:        return 1;
			VT_U16, VT_I16: return 2;
			VT_U32, VT_I32: return 4;
			default:        return 0;
		endcase
	endfunction

	// full scale of each type maps to 5000 mV; negative signed values clamp to 0
	function automatic logic [12:0] to_millivolts(input logic [2:0] vt, input logic [31:0] raw);
		logic [63:0] q;
		q = '0;
		case (vt)
			VT_BOOL: q = (raw[7:0] != 8'd0) ? 64'(FULL_MV) : 64'd0;
			VT_U16:  q = (64'(raw[15:0]) * 64'(FULL_MV)) / 64'd65535;
			VT_U32:  q = (64'(raw) * 64'(FULL_MV)) / 64'd4294967295;
			VT_I16:  if (!raw[15]) q = (64'(raw[14:0]) * 64'(FULL_MV)) / 64'd32767;
			default: if (!raw[31]) q = (64'(raw) * 64'(FULL_MV)) / 64'd2147483647;
		endcase
		return q[12:0];
	endfunction

	function automatic void predict_matches(input in_item_t it);
		int          nbytes;
		int          sh;
		logic [3:0]  dlc;
		logic [31:0] raw;
		result_t     r;
		result_t     held;
		logic        have_held;
		have_held = 1'b0;
		held = '0;
		dlc = (it.dlc > MAX_DLC) ? MAX_DLC : it.dlc;
		for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
			if (!filters[i].used || filters[i].bus != it.bus || filters[i].id != it.frame_id)
				continue;
			r = '0;
			r.match_index = 4'(i);
			nbytes = field_bytes(filters[i].vtype);
			if (nbytes == 0) begin
				r.status = ST_UNSUP;
			end else if (int'(filters[i].offset) + nbytes > int'(dlc)) begin
				r.status = ST_SHORT;
			end else begin
				raw = '0;
				for (int k = 0; k < nbytes; k++) begin
					sh = 8 * ((int'(filters[i].offset) + k) % 8);
					raw[8*k +: 8] = it.payload[sh +: 8];
				end
				r.status   = ST_OK;
				r.level_mv = to_millivolts(filters[i].vtype, raw);
				if (r.level_mv > high_mv)
					trig[i] = 1'b1;
				else if (r.level_mv < low_mv)
					trig[i] = 1'b0;
			end
			r.trigger_out = trig[i];
			if (have_held)
				match_q.push_back(held);
			held = r;
			have_held = 1'b1;
		end
		if (have_held) begin
			held.last = 1'b1;
			match_q.push_back(held);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES_DEF; i++) begin
				filters[i] = '0;
				trig[i]    = 1'b0;
			end
			high_mv = HIGH_THR_RST;
			low_mv  = LOW_THR_RST;
			match_q.delete();
			pend_cnt = 0;
		end else begin
			if (result_valid) begin
				if (match_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat: entry %0d status %0d level %0d",
						result.match_index, result.status, result.level_mv));
				end else begin
					want = match_q.pop_front();
					if (result.match_index !== want.match_index || result.status !== want.status ||
							result.level_mv !== want.level_mv ||
							result.trigger_out !== want.trigger_out || result.last !== want.last)
						report_mismatch($sformatf(
							"idx/st/mv/trig/last got %0d/%0d/%0d/%0d/%0d exp %0d/%0d/%0d/%0d/%0d",
							result.match_index, result.status, result.level_mv,
							result.trigger_out, result.last, want.match_index, want.status,
							want.level_mv, want.trigger_out, want.last));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_HIGH_THR: high_mv = cfg_wdata;
					CFG_LOW_THR:  low_mv  = cfg_wdata;
				endcase
			end
			if (start && !busy) begin
				if (in_item.opcode == OP_TABLE_WR) begin
					// table write leaves the entry's trigger alone
					filters[in_item.entry_index].used   = in_item.entry_used;
					filters[in_item.entry_index].bus    = in_item.bus;
					filters[in_item.entry_index].id     = in_item.frame_id;
					filters[in_item.entry_index].offset = in_item.entry_offset;
					filters[in_item.entry_index].vtype  = in_item.entry_type;
				end else begin
					predict_matches(in_item);
				end
			end
			pend_cnt = match_q.size();
		end
	end

endmodule

// File: tb/sv/tb_can_signal_extract_schmitt.sv
module tb_can_signal_extract_schmitt import cse_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    in_item;
	logic        result_valid;
	result_t     result;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_wdata;
	int          pending;
	int          mismatches;

	logic [1:0]  key_bus [4];
	logic [28:0] key_id [4];
	int          burst_left = 0;
	logic [12:0] high_tab [6];
	logic [12:0] low_tab [6];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	can_signal_extract_schmitt dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.in_item      (in_item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	cse_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.in_item      (in_item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pending      (pending),
		.mismatches   (mismatches)
	);

	function automatic in_item_t noise_item();
		in_item_t it;
		it.opcode       = OP_FRAME;
		it.bus          = 2'($urandom);
		it.frame_id     = 29'($urandom);
		it.dlc          = 4'($urandom);
		it.payload      = {$urandom, $urandom};
		it.entry_index  = 4'($urandom);
		it.entry_used   = 1'($urandom);
		it.entry_offset = 3'($urandom);
		it.entry_type   = 3'($urandom);
		return it;
	endfunction

	function automatic in_item_t tbl_write(input logic [3:0] idx, input logic used,
			input logic [1:0] b, input logic [28:0] id, input logic [2:0] off,
			input logic [2:0] vt);
		in_item_t it;
		it = noise_item();
		it.opcode       = OP_TABLE_WR;
		it.bus          = b;
		it.frame_id     = id;
		it.entry_index  = idx;
		it.entry_used   = used;
		it.entry_offset = off;
		it.entry_type   = vt;
		return it;
	endfunction

	function automatic in_item_t rx_frame(input logic [1:0] b, input logic [28:0] id,
			input logic [3:0] dlc, input logic [63:0] pl);
		in_item_t it;
		it = noise_item();
		it.bus      = b;
		it.frame_id = id;
		it.dlc      = dlc;
		it.payload  = pl;
		return it;
	endfunction

	// mostly writes and frames on a few shared keys so entries match often
	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		int       k;
		int       t;
		it = noise_item();
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		if (r < 25) begin
			it.opcode     = OP_TABLE_WR;
			it.bus        = key_bus[k];
			it.frame_id   = key_id[k];
			it.entry_used = ($urandom_range(0, 4) != 0);
			t = $urandom_range(0, 11);
			it.entry_type = (t < 8) ? 3'(t) : 3'($urandom_range(0, 4));
		end else if (r < 90) begin
			it.bus      = key_bus[k];
			it.frame_id = key_id[k];
			if ($urandom_range(0, 9) < 7)
				it.dlc = MAX_DLC;
			case ($urandom_range(0, 9))
				0: it.payload = '0;
				1: it.payload = '1;
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic send_beat(input in_item_t it);
		int   gap;
		logic taken;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				burst_left = $urandom_range(4, 16);
			gap = $urandom_range(0, 18);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		in_item <= it;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		@(negedge clk);
	endtask

	// frames with no match and table writes leave nothing pending; the extra
	// cycles cover a frame scan still in flight
	task automatic drain_idle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_threshold(input logic idx, input logic [12:0] mv);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= mv;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_HIGH_THR;
		cfg_wdata = '0;
		key_bus[0] = 2'd3;
		key_id[0]  = 29'h1FFF_FFFF;
		key_bus[1] = 2'd0;
		key_id[1]  = 29'd0;
		for (int k = 2; k < 4; k++) begin
			key_bus[k] = 2'($urandom);
			key_id[k]  = 29'($urandom);
		end
		high_tab = '{13'd5000, 13'd0, 13'd0, 13'd5000, 13'($urandom_range(0, 5000)), 13'd3000};
		low_tab  = '{13'd0, 13'd5000, 13'd0, 13'd5000, 13'($urandom_range(0, 5000)), 13'd2000};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every type, offsets up to the frame end, short and unsupported
		// entries, disabled entries, oversized dlc, sign clamp and a mid-band level
		send_beat(tbl_write(4'd0,  1'b1, 2'd3, 29'h1FFF_FFFF, 3'd0, VT_BOOL));
		send_beat(tbl_write(4'd1,  1'b1, 2'd3, 29'h1FFF_FFFF, 3'd1, VT_U16));
		send_beat(tbl_write(4'd2,  1'b1, 2'd3, 29'h1FFF_FFFF, 3'd4, VT_U32));
		send_beat(tbl_write(4'd15, 1'b1, 2'd3, 29'h1FFF_FFFF, 3'd6, VT_I16));
		send_beat(tbl_write(4'd7,  1'b1, 2'd0, 29'd0, 3'd0, VT_I32));
		send_beat(tbl_write(4'd8,  1'b1, 2'd0, 29'd0, 3'd3, 3'd5));
		send_beat(tbl_write(4'd9,  1'b0, 2'd0, 29'd0, 3'd0, VT_U16));
		send_beat(tbl_write(4'd10, 1'b1, 2'd0, 29'd0, 3'd7, 3'd7));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd8, '1));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd0, '1));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd15, '0));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd3, 64'h0000_0000_00FF_FF01));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd8, 64'h0000_0000_0080_0001));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd8, 64'h7FFF_0000_0000_0000));
		send_beat(rx_frame(2'd0, 29'd0, 4'd8, 64'h0000_0000_7FFF_FFFF));
		send_beat(rx_frame(2'd0, 29'd0, 4'd4, 64'h0000_0000_8000_0000));
		send_beat(rx_frame(2'd0, 29'd0, 4'd2, '1));
		send_beat(rx_frame(2'd1, 29'h0000_0123, 4'd8, '1));
		send_beat(rx_frame(2'd3, 29'd0, 4'd8, '1));
		send_beat(tbl_write(4'd0, 1'b0, 2'd3, 29'h1FFF_FFFF, 3'd0, VT_BOOL));
		send_beat(rx_frame(2'd3, 29'h1FFF_FFFF, 4'd9, 64'hFFFF_FFFF_0000_0000));
		drain_idle();

		for (int p = 0; p < 6; p++) begin
			write_threshold(CFG_HIGH_THR, high_tab[p]);
			write_threshold(CFG_LOW_THR, low_tab[p]);
			for (int n = 0; n < 50; n++)
				send_beat(random_item());
			drain_idle();
		end

		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/cse_pkg.sv
hw/rtl/cse_cell.sv
hw/rtl/cse_eval.sv
hw/rtl/can_signal_extract_schmitt.sv
tb/sv/cse_result_checker.sv
tb/sv/tb_can_signal_extract_schmitt.sv
